// ===== hw/rtl/spq_pkg.sv =====
// Package for the sorted priority queue: operation codes, entry and command types.
// No dependencies; every other file of the block imports it.
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_t;

  // Value sits in the low half so the input tdata maps straight onto it.
  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] value;
  } entry_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t data;
  } cmd_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg for the entry and command types.
module spq_cell (
  input  logic           clk,
  input  spq_pkg::cmd_t   cmd,
  input  logic           occupied,
  input  logic           prev_take,
  input  spq_pkg::entry_t prev_entry,
  input  spq_pkg::entry_t next_entry,
  output logic           take,
  output spq_pkg::entry_t entry
);
  import spq_pkg::*;

  // A cell gives way to the new pair when its own priority is equal or lower,
  // or when it holds nothing.
  always_comb begin
    take = occupied ? (cmd.data.prio >= entry.prio) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && take) begin
      entry <= prev_take ? prev_entry : cmd.data;
    end else if (cmd.del) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== hw/rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue built as a chain of CAPACITY cells, highest priority at
// cell 0. Every cell compares the incoming priority with its own in the same
// cycle and either keeps its pair, takes the new pair, or takes its neighbor's.
// One transfer is accepted per clock whenever the result register is free or
// being drained. The result is registered and appears in the cycle after the
// input transfer. An enqueue into a full queue is dropped and flagged; dequeue
// or peek of an empty queue is flagged with a zero value. Depends on spq_pkg
// and spq_cell.
module sorted_priority_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] item_value, [63:32] item_priority
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] head_value
  output logic [1:0]  m_tuser    // [0] was_empty, [1] overflow
);
  import spq_pkg::*;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic             fire;
  logic             is_empty;
  logic             is_full;
  kind_t            kind;
  cmd_t             cmd;
  logic [31:0]      head_next;
  logic [1:0]       flags_next;
  logic             take [CAPACITY];
  entry_t           cell_entry [CAPACITY];

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign kind     = kind_t'(s_tuser);
  assign is_empty = (fill_count == '0);
  assign is_full  = (fill_count == CNT_W'(CAPACITY));

  always_comb begin
    cmd.ins         = 1'b0;
    cmd.del         = 1'b0;
    cmd.data        = entry_t'(s_tdata);
    head_next       = '0;
    flags_next      = '0;
    fill_count_next = fill_count;
    case (kind)
      KIND_ENQ: begin
        if (is_full) begin
          flags_next[1] = 1'b1;
        end else begin
          cmd.ins         = fire;
          fill_count_next = fill_count + CNT_W'(1);
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        if (is_empty) begin
          flags_next[0] = 1'b1;
        end else begin
          head_next = cell_entry[0].value;
          if (kind == KIND_DEQ) begin
            cmd.del         = fire;
            fill_count_next = fill_count - CNT_W'(1);
          end
        end
      end
      default: begin
        // Unused code: no operation, all-zero result.
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   prev_take;
    entry_t prev_entry;
    entry_t next_entry;

    assign occ = (CNT_W'(i) < fill_count);

    if (i == 0) begin : g_head
      assign prev_take  = 1'b0;
      assign prev_entry = cmd.data;
    end else begin : g_body
      assign prev_take  = take[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_mid
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occ),
      .prev_take  (prev_take),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .take       (take[i]),
      .entry      (cell_entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (fire) begin
        fill_count <= fill_count_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= head_next;
      m_tuser <= flags_next;
    end
  end

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, attached to the top level by bind.
// Depends on spq_pkg for the operation codes.
module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import spq_pkg::*;

  // A result that is not taken stays on offer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // Every accepted transfer yields a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // Empty and overflow cannot both be reported for one item.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("both status flags set");

  // An enqueue result never carries a value or an empty flag.
  a_enq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_ENQ) |=> (m_tdata == '0) && !m_tuser[0])
    else $error("enqueue result not zero");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

// ===== verif/tb_sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_unit: random streams of enqueue,
// dequeue and peek are checked against a behavioral priority queue kept in the bench.
// Depends on spq_pkg and the RTL of the block; reads no files.
module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int RANDOM_OPS = 750;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [31:0] prio;
  } queue_op_t;

  typedef struct packed {
    logic [31:0] head;
    logic        empty;
    logic        ovf;
  } queue_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] item_value, [63:32] item_priority
  logic [1:0]  s_tuser = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] head_value
  logic [1:0]  m_tuser;        // [0] was_empty, [1] overflow

  queue_op_t     ops_to_send[$];
  queue_answer_t answers_due[$];
  entry_t        held[$];        // bench copy of the queue contents, head first
  queue_op_t     driven;
  queue_answer_t due_now;

  int  ops_total = -1;
  int  sent = 0;
  int  gen_fill = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  logic hold_off = 1'b0;
  int  errors = 0;
  int  results_seen = 0;
  int  overflows_seen = 0;
  int  empties_seen = 0;
  int  hits_seen = 0;

  sorted_priority_queue_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 40)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // Applies one operation to the bench queue and returns the result it must give.
  function automatic queue_answer_t model_queue_op(input queue_op_t op);
    queue_answer_t ans;
    entry_t        fresh;
    int            pos;
    ans = '0;
    pos = 0;
    case (op.kind)
      KIND_ENQ: begin
        if (held.size() >= CAPACITY) begin
          ans.ovf = 1'b1;
        end else begin
          fresh.value = op.value;
          fresh.prio  = op.prio;
          // Ties go ahead of the stored pairs, so the newest of a priority leaves first.
          while (pos < held.size() && fresh.prio < held[pos].prio) pos++;
          held.insert(pos, fresh);
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        if (held.size() == 0) begin
          ans.empty = 1'b1;
        end else begin
          ans.head = held[0].value;
          if (op.kind == KIND_DEQ) void'(held.pop_front());
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 8) - 4;
    if (r < 6) begin
      case ($urandom_range(0, 5))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h7FFF_FFFE;
        3: return 32'h8000_0001;
        4: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  // Queues one operation and tracks the fill level so that sequences can be planned.
  task automatic push_op(input logic [1:0] kind, input logic [31:0] value,
                         input logic [31:0] prio);
    queue_op_t op;
    op.kind  = kind;
    op.value = value;
    op.prio  = prio;
    ops_to_send.push_back(op);
    if (kind == KIND_ENQ && gen_fill < CAPACITY) gen_fill++;
    if (kind == KIND_DEQ && gen_fill > 0) gen_fill--;
  endtask

  // Sender: a new item goes out once the previous one has been transferred.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        answers_due.push_back(model_queue_op(driven));
        sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_tvalid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          driven = ops_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {driven.prio, driven.value};
          s_tuser  <= driven.kind;
          if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
          tx_wait = pick_gap(tx_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", m_tdata, '0);
        end else begin
          due_now = answers_due.pop_front();
          if (m_tdata !== due_now.head) report_mismatch("head_value", m_tdata, due_now.head);
          if (m_tuser[0] !== due_now.empty)
            report_mismatch("was_empty", m_tuser[0], due_now.empty);
          if (m_tuser[1] !== due_now.ovf) report_mismatch("overflow", m_tuser[1], due_now.ovf);
          results_seen++;
          if (due_now.ovf) overflows_seen++;
          if (due_now.empty) empties_seen++;
          if (due_now.head != 0) hits_seen++;
        end
      end
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_wait = pick_gap(rx_calm);
      end
    end
  end

  // One long receiver stall mid-run, so the result register fills and input backs up.
  initial begin
    while (rst || sent < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_sorted_priority_queue_unit: done, errors");
    $finish;
  end

  initial begin
    int pick;
    int n;

    // Empty reads, the unused kind, extremes and a three-way priority tie.
    push_op(KIND_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(KIND_PEEK, 32'h1234_5678, 32'h0);
    push_op(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(KIND_ENQ, 32'h7FFF_FFFF, 32'h0);
    push_op(KIND_ENQ, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(KIND_ENQ, 32'h0, 32'h8000_0000);
    push_op(KIND_ENQ, 32'hFFFF_FFFF, 32'h0);
    push_op(KIND_ENQ, 32'h1, 32'h0);
    push_op(KIND_PEEK, 32'h0, 32'h0);
    push_op(KIND_NOP, 32'h0, 32'h0);
    repeat (5) push_op(KIND_DEQ, 32'h0, 32'h0);
    push_op(KIND_DEQ, 32'h0, 32'h0);
    push_op(KIND_PEEK, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    push_op(KIND_ENQ, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    push_op(KIND_PEEK, 32'h0, 32'h0);
    push_op(KIND_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    n = ops_to_send.size() + RANDOM_OPS;
    while (ops_to_send.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(1, 12)) push_op(KIND_ENQ, rand_value(), rand_prio());
        repeat ($urandom_range(1, 14))
          push_op(($urandom_range(0, 3) == 0) ? KIND_PEEK : KIND_DEQ, rand_value(), rand_prio());
      end else if (pick < 62) begin
        // Run the queue past full, then drain it and read it empty once more.
        repeat (CAPACITY - gen_fill + $urandom_range(1, 3))
          push_op(KIND_ENQ, rand_value(), rand_prio());
        repeat (gen_fill + $urandom_range(1, 2)) push_op(KIND_DEQ, rand_value(), rand_prio());
      end else begin
        repeat ($urandom_range(1, 6))
          push_op(2'($urandom_range(0, 3)), rand_value(), rand_prio());
      end
    end
    ops_total = ops_to_send.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (sent < ops_total) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d operations and checked %0d results.", ops_total, results_seen);
    $display("Results with a value: %0d, empty reads: %0d, dropped enqueues: %0d.",
             hits_seen, empties_seen, overflows_seen);
    if (errors == 0) begin
      $display("tb_sorted_priority_queue_unit: done, clean");
    end else begin
      $display("tb_sorted_priority_queue_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_unit.sv
hw/rtl/spq_checker.sv
verif/tb_sorted_priority_queue_unit.sv
